/* hdl/fdw_pkg.sv */
// types and constants shared by the fat32 directory walker modules
`default_nettype none
package fdw_pkg;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_ENTRY = 2'd1,
      CMD_FAT   = 2'd2,
      CMD_FAIL  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_READ = 3'd0,
      KIND_FILE = 3'd1,
      KIND_FAT  = 3'd2,
      KIND_END  = 3'd3,
      KIND_ERR  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_ENTRIES = 2'd1,
      PH_FAT     = 2'd2
   } phase_type;

   localparam logic [2:0] CSR_FIRST_FAT_SECTOR    = 3'd0;
   localparam logic [2:0] CSR_FAT_SECTOR_COUNT    = 3'd1;
   localparam logic [2:0] CSR_FIRST_DATA_SECTOR   = 3'd2;
   localparam logic [2:0] CSR_SECTORS_PER_CLUSTER = 3'd3;
   localparam logic [2:0] CSR_ROOT_CLUSTER        = 3'd4;

   localparam logic [31:0] EOC_MASK     = 32'h0FFF_FFF8;
   localparam logic [7:0]  ATTR_LFN     = 8'h0F;
   localparam logic [7:0]  ATTR_VOLUME  = 8'h08;
   localparam logic [7:0]  ATTR_DIR     = 8'h10;
   localparam logic [7:0]  NAME_DELETED = 8'hE5;
   localparam logic [7:0]  NAME_FREE    = 8'h00;

   // 128 fat words per 512 byte sector
   localparam int FAT_SHIFT = 7;

   typedef struct packed {
      cmd_type     cmd;
      logic        keep;
      logic        is_dir;
      logic        eoc;
      logic [31:0] cluster;
      logic [31:0] size;
   } op_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] read_lba;
      logic [6:0]  fat_index;
      logic        dir_flag;
      logic [31:0] file_cluster;
      logic [31:0] file_size;
      logic        last;
   } rsp_type;

endpackage
`default_nettype wire

/* hdl/fdw_fifo.sv */
// small generic register queue with registered storage
`default_nettype none
module fdw_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* hdl/fdw_front.sv */
// front end: decodes incoming words into queued operations and marks which entries to keep
`default_nettype none
module fdw_front
   import fdw_pkg::*;
(
   input  wire logic [1:0]   req_tuser,
   input  wire logic [111:0] req_tdata,
   output op_type            op
);

   logic [7:0]  attr;
   logic [7:0]  name0;
   logic [31:0] ecl;
   logic [31:0] esz;
   logic [31:0] fv;

   assign attr  = req_tdata[7:0];
   assign name0 = req_tdata[15:8];
   assign ecl   = req_tdata[47:16];
   assign esz   = req_tdata[79:48];
   assign fv    = req_tdata[111:80];

   always_comb begin
      op.cmd     = cmd_type'(req_tuser);
      op.keep    = ((attr & ATTR_LFN) != ATTR_LFN) && ((attr & ATTR_VOLUME) == '0)
                   && (name0 != NAME_FREE) && (name0 != NAME_DELETED);
      op.is_dir  = ((attr & ATTR_DIR) != '0);
      op.eoc     = ((fv & EOC_MASK) == EOC_MASK);
      op.cluster = (op.cmd == CMD_FAT) ? fv : ecl;
      op.size    = esz;
   end

endmodule
`default_nettype wire

/* hdl/fdw_back.sv */
// back end: walk state machine, config registers and two-word result buffer
`default_nettype none
module fdw_back
   import fdw_pkg::*;
#(
   parameter int ENTRIES_PER_SECTOR = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        op_valid,
   output logic             op_ready,
   input  wire op_type      op,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp
);

   localparam int EW = $clog2(ENTRIES_PER_SECTOR + 1);

   logic [31:0] ffs_ff, fsc_ff, fds_ff;
   logic [7:0]  spc_ff;
   logic [27:0] root_ff;

   phase_type   phase_ff, phase_in;
   logic [31:0] cur_ff, cur_in;
   logic [31:0] next_ff, next_in;
   logic [7:0]  left_ff, left_in;
   logic [EW-1:0] idx_ff, idx_in;

   rsp_type     slot0_ff, slot1_ff;
   logic [1:0]  cnt_ff;

   rsp_type     res_file, res_req, r0, r1;
   logic        has_file, has_req, load_read, take, fire;
   logic [31:0] ld_cl, ld_next, fat_offs;
   logic [39:0] ld_prod;
   logic [7:0]  spc_dec, left_dec;
   logic [EW-1:0] idx_inc;
   logic [1:0]  n_res;

   function automatic rsp_type mk(kind_type k, logic [31:0] a, logic [6:0] i,
                                  logic d, logic [31:0] c, logic [31:0] s);
      rsp_type r;
      r.kind         = k;
      r.read_lba     = a;
      r.fat_index    = i;
      r.dir_flag     = d;
      r.file_cluster = c;
      r.file_size    = s;
      r.last         = 1'b0;
      return r;
   endfunction

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp       = slot0_ff;
   assign fire      = rsp_valid && rsp_ready;
   assign op_ready  = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign take      = op_valid && op_ready;

   always_comb begin
      phase_in  = phase_ff;
      cur_in    = cur_ff;
      next_in   = next_ff;
      left_in   = left_ff;
      idx_in    = idx_ff;
      has_file  = 1'b0;
      has_req   = 1'b0;
      load_read = 1'b0;
      res_req   = mk(KIND_ERR, '0, '0, 1'b0, '0, '0);
      res_file  = mk(KIND_FILE, '0, '0, op.is_dir, op.cluster, op.size);
      ld_cl     = (op.cmd == CMD_START) ? {4'b0, root_ff} : op.cluster;
      ld_prod   = (ld_cl - 32'd2) * spc_ff;
      ld_next   = fds_ff + ld_prod[31:0];
      spc_dec   = spc_ff - 8'd1;
      left_dec  = left_ff - 8'd1;
      idx_inc   = idx_ff + 1'b1;
      fat_offs  = {{FAT_SHIFT{1'b0}}, cur_ff[31:FAT_SHIFT]};

      case (op.cmd)
         CMD_START: begin
            cur_in    = ld_cl;
            load_read = 1'b1;
         end
         CMD_ENTRY: begin
            if (phase_ff == PH_ENTRIES) begin
               idx_in   = idx_inc;
               has_file = op.keep;
               if (idx_inc >= EW'(ENTRIES_PER_SECTOR)) begin
                  has_req = 1'b1;
                  if (left_ff == '0) begin
                     if (cur_ff < {4'b0, root_ff} || fat_offs >= fsc_ff) begin
                        phase_in = PH_IDLE;
                     end else begin
                        res_req  = mk(KIND_FAT, ffs_ff + fat_offs,
                                      cur_ff[FAT_SHIFT-1:0], 1'b0, '0, '0);
                        phase_in = PH_FAT;
                     end
                  end else begin
                     res_req = mk(KIND_READ, next_ff, '0, 1'b0, '0, '0);
                     left_in = left_dec;
                     next_in = (left_dec != '0) ? next_ff + 32'd1 : next_ff;
                     idx_in  = '0;
                  end
               end
            end
         end
         CMD_FAT: begin
            if (phase_ff == PH_FAT) begin
               cur_in = op.cluster;
               if (op.eoc) begin
                  has_req  = 1'b1;
                  res_req  = mk(KIND_END, '0, '0, 1'b0, '0, '0);
                  phase_in = PH_IDLE;
               end else begin
                  load_read = 1'b1;
               end
            end
         end
         CMD_FAIL: begin
            if (phase_ff != PH_IDLE) begin
               has_req  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
         end
      endcase

      if (load_read) begin
         has_req = 1'b1;
         left_in = spc_ff;
         next_in = ld_next;
         if (spc_ff == '0) begin
            phase_in = PH_IDLE;
         end else begin
            res_req  = mk(KIND_READ, ld_next, '0, 1'b0, '0, '0);
            left_in  = spc_dec;
            next_in  = (spc_dec != '0) ? ld_next + 32'd1 : ld_next;
            idx_in   = '0;
            phase_in = PH_ENTRIES;
         end
      end

      res_file.last = !has_req;
      res_req.last  = 1'b1;
      r0    = has_file ? res_file : res_req;
      r1    = res_req;
      n_res = {1'b0, has_file} + {1'b0, has_req};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cur_ff   <= '0;
         next_ff  <= '0;
         left_ff  <= '0;
         idx_ff   <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         cur_ff   <= cur_in;
         next_ff  <= next_in;
         left_ff  <= left_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ffs_ff  <= '0;
         fsc_ff  <= '0;
         fds_ff  <= '0;
         spc_ff  <= 8'd1;
         root_ff <= 28'd2;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIRST_FAT_SECTOR:    ffs_ff  <= csr_wdata;
            CSR_FAT_SECTOR_COUNT:    fsc_ff  <= csr_wdata;
            CSR_FIRST_DATA_SECTOR:   fds_ff  <= csr_wdata;
            CSR_SECTORS_PER_CLUSTER: spc_ff  <= csr_wdata[7:0];
            CSR_ROOT_CLUSTER:        root_ff <= csr_wdata[27:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (take) begin
         cnt_ff <= n_res;
      end else if (fire) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         slot0_ff <= r0;
         slot1_ff <= r1;
      end else if (fire) begin
         slot0_ff <= slot1_ff;
      end
   end

endmodule
`default_nettype wire

/* hdl/fat32_directory_walker_unit.sv */
// top level of the fat32 directory walker
//
//   channel | ports        | tuser          | tdata / data
//   in      | req_t*       | [1:0] cmd      | see port comment
//   out     | rsp_t*       | [2:0] kind     | see port comment, tlast = last
//   config  | csr_*        | -              | csr_index selects register
//
// one word is accepted per cycle while the queue has room; it is stored in
// the queue, and when the back end takes it its results are registered in
// the result buffer, from which the first result is offered. a word giving
// a file entry plus a request holds the back end while both of its results
// wait in that buffer. the data sector address uses one 32x8 multiply in the
// back end. reset is synchronous and returns the walk to idle with the
// default register values. either side may stall freely.
`default_nettype none
module fat32_directory_walker_unit
   import fdw_pkg::*;
#(
   parameter int ENTRIES_PER_SECTOR = 16,
   parameter int QUEUE_DEPTH        = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // entry_attributes, entry_name_first, entry_cluster, entry_size, fat_value
   input  wire logic [111:0] req_tdata,
   // cmd
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // read_lba, fat_index, dir_flag, file_cluster, file_size
   output logic [103:0]      rsp_tdata,
   // kind
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);

   op_type  op_push, op_pop;
   logic    op_valid, op_ready;
   rsp_type rsp;

   fdw_front u_front (
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .op        (op_push)
   );

   fdw_fifo #(
      .WIDTH ($bits(op_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_data  (op_push),
      .pop_valid  (op_valid),
      .pop_ready  (op_ready),
      .pop_data   (op_pop)
   );

   fdw_back #(
      .ENTRIES_PER_SECTOR (ENTRIES_PER_SECTOR)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op_ready  (op_ready),
      .op        (op_pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {rsp.file_size, rsp.file_cluster, rsp.dir_flag,
                       rsp.fat_index, rsp.read_lba};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

endmodule
`default_nettype wire
